// File: src/legendre_symbol_search_defines.svh
// Assertion helpers used by the design file.
`ifndef LEGENDRE_SYMBOL_SEARCH_DEFINES_SVH
`define LEGENDRE_SYMBOL_SEARCH_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define LSS_ASSERT_IMP(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("implication check failed");

// Next-cycle implication, checked outside reset.
`define LSS_ASSERT_NXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("next-cycle check failed");

`endif

// File: src/lss_pkg.sv
`default_nettype none
package lss_pkg;
	localparam int MODULUS_WIDTH_DEF = 16;
	localparam int VALUE_WIDTH       = 32;
	localparam int MODULUS_IN_WIDTH  = 16;
	localparam int CNT_WIDTH         = $clog2(VALUE_WIDTH);

	localparam logic [1:0] SYM_ZERO = 2'b00;
	localparam logic [1:0] SYM_POS  = 2'b01;
	localparam logic [1:0] SYM_NEG  = 2'b11;
endpackage
`default_nettype wire

// File: src/legendre_symbol_search.sv
// Sequence: for a zero modulus the result is valid in the cycle after the request is taken;
// otherwise restoring division (one quotient bit per cycle), a sign fix, rule checks, then up
// to floor(modulus/2) square-compare steps.
// Requests: one at a time (in_stall is high outside idle); idle again in the cycle after the
// result is taken.
// Reset: arst_n clears the sequencer and the output valid at once; no memory to clear.
`default_nettype none
`include "legendre_symbol_search_defines.svh"
module legendre_symbol_search #(
	parameter int MODULUS_WIDTH = lss_pkg::MODULUS_WIDTH_DEF
) (
	input  wire logic                                  clk,
	input  wire logic                                  arst_n,
	input  wire logic                                  in_valid,
	output logic                                       in_stall,
	input  wire logic signed [lss_pkg::VALUE_WIDTH-1:0] value,
	input  wire logic [lss_pkg::MODULUS_IN_WIDTH-1:0]  modulus,
	output logic                                       out_valid,
	input  wire logic                                  out_stall,
	output logic signed [1:0]                          symbol
);
	localparam int W  = MODULUS_WIDTH;
	localparam int VW = lss_pkg::VALUE_WIDTH;
	localparam int CW = lss_pkg::CNT_WIDTH;

	typedef enum logic [5:0] {
		ST_IDLE   = 6'b000001,
		ST_DIV    = 6'b000010,
		ST_FIX    = 6'b000100,
		ST_RULE   = 6'b001000,
		ST_SEARCH = 6'b010000,
		ST_DONE   = 6'b100000
	} state_t;

	state_t          state_q;
	logic [W-1:0]    p_q;
	logic [W-1:0]    rem_q;
	logic [VW-1:0]   div_q;
	logic [CW-1:0]   cnt_q;
	logic            neg_q;
	logic [W-1:0]    idx_q;
	logic [W-1:0]    sq_q;
	logic [W-1:0]    d_q;
	logic [1:0]      symbol_q;

	logic [63:0]     mod_ext;
	logic [W-1:0]    p_in;
	logic [VW-1:0]   mag;
	logic [63:0]     p_wide;
	logic [2:0]      p_mod8;
	logic [W-1:0]    half;
	logic [W:0]      p_ext;
	logic [W:0]      trial;
	logic [W:0]      sq_sum;
	logic [W:0]      d_sum;
	logic [W-1:0]    sq_nx;
	logic [W-1:0]    d_nx;
	logic [W-1:0]    first_d;

	always_comb begin
		mod_ext = {{(64-lss_pkg::MODULUS_IN_WIDTH){1'b0}}, modulus};
		p_in    = mod_ext[W-1:0];
		mag     = value[VW-1] ? (~value + 1'b1) : value;
		p_wide  = {{(64-W){1'b0}}, p_q};
		p_mod8  = p_wide[2:0];
		half    = p_q >> 1;
		p_ext   = {1'b0, p_q};
		trial   = {rem_q, div_q[VW-1]};
		sq_sum  = {1'b0, sq_q} + {1'b0, d_q};
		d_sum   = {1'b0, d_q} + (W+1)'(2);
		sq_nx   = (sq_sum >= p_ext) ? W'(sq_sum - p_ext) : sq_sum[W-1:0];
		d_nx    = (d_sum >= p_ext) ? W'(d_sum - p_ext) : d_sum[W-1:0];
		first_d = (p_q == W'(3)) ? '0 : W'(3);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						state_q <= (p_in == '0) ? ST_DONE : ST_DIV;
					end
				end
				ST_DIV: begin
					if (cnt_q == '0) begin
						state_q <= ST_FIX;
					end
				end
				ST_FIX: state_q <= ST_RULE;
				ST_RULE: begin
					if (rem_q == '0 || p_q == W'(2) || rem_q == W'(2) ||
					    rem_q == p_q - 1'b1) begin
						state_q <= ST_DONE;
					end else begin
						state_q <= ST_SEARCH;
					end
				end
				ST_SEARCH: begin
					if (sq_q == rem_q || idx_q == half) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (!out_stall) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				p_q      <= p_in;
				div_q    <= mag;
				neg_q    <= value[VW-1];
				rem_q    <= '0;
				cnt_q    <= CW'(VW - 1);
				symbol_q <= lss_pkg::SYM_ZERO;
			end
			ST_DIV: begin
				rem_q <= (trial >= p_ext) ? W'(trial - p_ext) : trial[W-1:0];
				div_q <= div_q << 1;
				cnt_q <= cnt_q - 1'b1;
			end
			ST_FIX: begin
				if (neg_q && rem_q != '0) begin
					rem_q <= p_q - rem_q;
				end
			end
			ST_RULE: begin
				idx_q <= W'(1);
				sq_q  <= W'(1);
				d_q   <= first_d;
				if (rem_q == '0) begin
					symbol_q <= lss_pkg::SYM_ZERO;
				end else if (p_q == W'(2)) begin
					symbol_q <= lss_pkg::SYM_POS;
				end else if (rem_q == W'(2)) begin
					symbol_q <= (p_mod8 == 3'd1 || p_mod8 == 3'd7) ?
						lss_pkg::SYM_POS : lss_pkg::SYM_NEG;
				end else if (rem_q == p_q - 1'b1) begin
					symbol_q <= (p_mod8[1:0] == 2'd1) ? lss_pkg::SYM_POS : lss_pkg::SYM_NEG;
				end
			end
			ST_SEARCH: begin
				if (sq_q == rem_q) begin
					symbol_q <= lss_pkg::SYM_POS;
				end else if (idx_q == half) begin
					symbol_q <= lss_pkg::SYM_NEG;
				end else begin
					sq_q  <= sq_nx;
					d_q   <= d_nx;
					idx_q <= idx_q + 1'b1;
				end
			end
			default: begin
			end
		endcase
	end

	assign in_stall  = (state_q != ST_IDLE);
	assign out_valid = (state_q == ST_DONE);
	assign symbol    = symbol_q;

	`LSS_ASSERT_NXT(a_zero_mod, in_valid && !in_stall && p_in == '0, out_valid && symbol == lss_pkg::SYM_ZERO)
	`LSS_ASSERT_IMP(a_rem_range, state_q == ST_RULE || state_q == ST_SEARCH, rem_q < p_q)
	`LSS_ASSERT_IMP(a_sq_range, state_q == ST_SEARCH, sq_q < p_q && d_q < p_q)
	`LSS_ASSERT_IMP(a_idx_range, state_q == ST_SEARCH, idx_q <= half && idx_q != '0)
	`LSS_ASSERT_IMP(a_sym_code, out_valid, symbol != 2'sb10)
endmodule
`default_nettype wire
